FILE: sv/m3i_pkg.sv
`default_nettype none
package m3i_pkg;

  localparam int N_EL        = 9;
  localparam int EW          = 32;
  localparam int CW          = 64;
  localparam int DW          = 97;
  localparam int THR_W       = 25;
  localparam int ST_W        = 2;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_LAT     = DIV_STEPS + 2;
  localparam int FRONT_LAT   = 6;
  localparam int PIPE_LEN    = FRONT_LAT + DIV_LAT;
  localparam int IN_TDATA_W  = 288;
  localparam int OUT_TDATA_W = 328;

  localparam logic [THR_W-1:0] THR_RESET = 25'd168;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_SINGULAR = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT      = 2'd2;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic [CW-1:0]        cmag_t;
  typedef logic signed [DW-1:0] dsgn_t;
  typedef logic [DW-1:0]        dmag_t;
  typedef logic [3:0]           idx_t;

  // cofactor k = m[PA]*m[PB] - m[NA]*m[NB]
  localparam idx_t PA [N_EL] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam idx_t PB [N_EL] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam idx_t NA [N_EL] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam idx_t NB [N_EL] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

  // determinant facts that ride along beside the divider lanes
  typedef struct packed {
    elem_t det;
    logic  dsat;
    logic  sing;
  } info_t;

endpackage
`default_nettype wire

FILE: sv/m3i_cof.sv
`default_nettype none
module m3i_cof (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire m3i_pkg::elem_t m [m3i_pkg::N_EL],
  output m3i_pkg::cof_t       c_r [m3i_pkg::N_EL],
  output m3i_pkg::elem_t      e_r [3]
);

  m3i_pkg::cof_t  pa_r [m3i_pkg::N_EL];
  m3i_pkg::cof_t  pb_r [m3i_pkg::N_EL];
  m3i_pkg::elem_t eb_r [3];

  // form the 18 products, then the cofactor differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < m3i_pkg::N_EL; k++) begin
        pa_r[k] <= m[m3i_pkg::PA[k]] * m[m3i_pkg::PB[k]];
        pb_r[k] <= m[m3i_pkg::NA[k]] * m[m3i_pkg::NB[k]];
        c_r[k]  <= pa_r[k] - pb_r[k];
      end
      for (int j = 0; j < 3; j++) begin
        eb_r[j] <= m[3*j];
        e_r[j]  <= eb_r[j];
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/m3i_det.sv
`default_nettype none
module m3i_det (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire m3i_pkg::cof_t  c [m3i_pkg::N_EL],
  input  wire m3i_pkg::elem_t e [3],
  output m3i_pkg::dmag_t      dm_r,
  output logic                dneg_r,
  output m3i_pkg::cmag_t      cm_r [m3i_pkg::N_EL],
  output logic                cneg_r [m3i_pkg::N_EL]
);

  logic signed [m3i_pkg::EW+32:0] plo_r [3];
  logic signed [m3i_pkg::CW-1:0]  phi_r [3];
  m3i_pkg::cof_t                  cd_r [m3i_pkg::N_EL];
  m3i_pkg::cof_t                  ce_r [m3i_pkg::N_EL];
  m3i_pkg::dsgn_t                 d_r;
  m3i_pkg::dsgn_t                 dsum;

  // add the partial products of the first-column expansion
  always_comb begin
    dsum = '0;
    for (int k = 0; k < 3; k++) begin
      dsum = dsum + (m3i_pkg::dsgn_t'(phi_r[k]) <<< 32) + m3i_pkg::dsgn_t'(plo_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // split each element-by-cofactor product into 32-bit halves
      for (int k = 0; k < 3; k++) begin
        plo_r[k] <= e[k] * $signed({1'b0, c[k][31:0]});
        phi_r[k] <= e[k] * $signed(c[k][63:32]);
      end
      d_r    <= dsum;
      dneg_r <= d_r[m3i_pkg::DW-1];
      dm_r   <= d_r[m3i_pkg::DW-1] ? m3i_pkg::dmag_t'(-d_r) : m3i_pkg::dmag_t'(d_r);
      for (int k = 0; k < m3i_pkg::N_EL; k++) begin
        cd_r[k]   <= c[k];
        ce_r[k]   <= cd_r[k];
        cneg_r[k] <= ce_r[k][m3i_pkg::CW-1];
        cm_r[k]   <= ce_r[k][m3i_pkg::CW-1] ? m3i_pkg::cmag_t'(-ce_r[k])
                                            : m3i_pkg::cmag_t'(ce_r[k]);
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/m3i_lane.sv
`default_nettype none
module m3i_lane (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire m3i_pkg::cmag_t cm,
  input  wire logic           neg,
  input  wire m3i_pkg::dmag_t dm,
  output m3i_pkg::elem_t      val_r,
  output logic                sat_r
);

  localparam int S = m3i_pkg::DIV_STEPS;

  m3i_pkg::dmag_t      r_r   [S+1];
  m3i_pkg::dmag_t      dm_r  [S+1];
  logic [S-1:0]        q_r   [S+1];
  logic                ovf_r [S+1];
  logic                neg_r [S+1];
  logic [m3i_pkg::DW:0] sh   [S];
  logic [S-1:0]        ge;
  logic                ovf;
  logic                rnd;
  logic [S:0]          qr;
  logic [S:0]          lim;
  logic [S:0]          mg;
  logic [S:0]          mneg;
  logic                sat;

  // quotient of 2^32 or more always clamps
  assign ovf = m3i_pkg::dmag_t'({cm, 16'b0}) >= dm;

  // one restoring step per stage
  always_comb begin
    for (int s = 0; s < S; s++) begin
      sh[s] = {r_r[s], 1'b0};
      ge[s] = sh[s] >= {1'b0, dm_r[s]};
    end
  end

  // round half up on the remainder, then clamp to the signed range
  always_comb begin
    rnd  = {r_r[S], 1'b0} >= {1'b0, dm_r[S]};
    qr   = {1'b0, q_r[S]} + {{S{1'b0}}, rnd};
    lim  = neg_r[S] ? 33'h080000000 : 33'h07FFFFFFF;
    sat  = ovf_r[S] || (qr > lim);
    mg   = sat ? lim : qr;
    mneg = '0 - mg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= m3i_pkg::dmag_t'({cm, 16'b0});
      q_r[0]   <= '0;
      dm_r[0]  <= dm;
      ovf_r[0] <= ovf;
      neg_r[0] <= neg;
      for (int s = 0; s < S; s++) begin
        r_r[s+1]   <= ge[s] ? sh[s][m3i_pkg::DW-1:0] - dm_r[s] : sh[s][m3i_pkg::DW-1:0];
        q_r[s+1]   <= {q_r[s][S-2:0], ge[s]};
        dm_r[s+1]  <= dm_r[s];
        ovf_r[s+1] <= ovf_r[s];
        neg_r[s+1] <= neg_r[s];
      end
      val_r <= neg_r[S] ? mneg[S-1:0] : mg[S-1:0];
      sat_r <= sat;
    end
  end

endmodule
`default_nettype wire

FILE: sv/matrix3_inverse_top.sv
// 3x3 matrix inverse by adjugate, signed Q8.24. One matrix enters per clock
// while no result is stalled at the output; the pipeline depth is set by the
// 32-stage restoring quotient pipeline that each of the nine lanes runs,
// one quotient bit per stage, behind six stages of products, cofactors and
// determinant. A determinant whose magnitude is zero or below the threshold
// register yields status singular and zero elements; otherwise any clamped
// element or clamped determinant yields status saturated. The whole
// pipeline holds while a result waits at the output.
`default_nettype none
module matrix3_inverse_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // in_m0 .. in_m8, 32 bits each, from bit 0 up
  input  wire logic [m3i_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // inv_m0 .. inv_m8, determinant (32 bits each), status (2), zero pad
  output logic [m3i_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [m3i_pkg::THR_W-1:0]          cfg_wdata
);

  localparam int NL = m3i_pkg::N_EL;
  localparam int PL = m3i_pkg::PIPE_LEN;

  logic                                 en;
  logic [m3i_pkg::THR_W-1:0]            thr_r;
  logic [PL-1:0]                        vld_r;
  m3i_pkg::elem_t                       m_r [NL];
  m3i_pkg::cof_t                        c   [NL];
  m3i_pkg::elem_t                       e   [3];
  m3i_pkg::dmag_t                       dm;
  logic                                 dneg;
  m3i_pkg::cmag_t                       cm  [NL];
  logic                                 cneg [NL];
  m3i_pkg::elem_t                       lane_val [NL];
  logic [NL-1:0]                        lane_sat;
  m3i_pkg::info_t                       info_nxt;
  m3i_pkg::info_t                       info_r [m3i_pkg::DIV_LAT];
  logic [49:0]                          dr;
  logic [49:0]                          dlim;
  logic [49:0]                          dmg;
  logic [49:0]                          dmneg;
  logic [m3i_pkg::ST_W-1:0]             status;
  logic [m3i_pkg::OUT_TDATA_W-1:0]      odata;
  logic                                 out_tvalid_r;
  logic [m3i_pkg::OUT_TDATA_W-1:0]      out_tdata_r;

  // advance the whole pipeline unless a result is held at the output
  assign en         = !out_tvalid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= m3i_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // valid bits of every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vld_r        <= {vld_r[PL-2:0], in_tvalid};
      out_tvalid_r <= vld_r[PL-1];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NL; k++) begin
        m_r[k] <= in_tdata[k*m3i_pkg::EW +: m3i_pkg::EW];
      end
    end
  end

  m3i_cof u_cof (
    .clk (clk),
    .en  (en),
    .m   (m_r),
    .c_r (c),
    .e_r (e)
  );

  m3i_det u_det (
    .clk    (clk),
    .en     (en),
    .c      (c),
    .e      (e),
    .dm_r   (dm),
    .dneg_r (dneg),
    .cm_r   (cm),
    .cneg_r (cneg)
  );

  // one divider lane per inverse element
  for (genvar k = 0; k < NL; k++) begin : g_lane
    m3i_lane u_lane (
      .clk   (clk),
      .en    (en),
      .cm    (cm[k]),
      .neg   ((cneg[k] ^ dneg) && (cm[k] != '0)),
      .dm    (dm),
      .val_r (lane_val[k]),
      .sat_r (lane_sat[k])
    );
  end

  // round and clamp the determinant, test for a singular matrix
  always_comb begin
    dr    = {1'b0, dm[m3i_pkg::DW-1:48]} + {49'b0, dm[47]};
    dlim  = dneg ? 50'h0_0000_8000_0000 : 50'h0_0000_7FFF_FFFF;
    info_nxt.dsat = dr > dlim;
    dmg   = info_nxt.dsat ? dlim : dr;
    dmneg = '0 - dmg;
    info_nxt.det  = dneg ? dmneg[31:0] : dmg[31:0];
    info_nxt.sing = (dm == '0) || (dm < {24'b0, thr_r, 48'b0});
  end

  // carry determinant facts alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      info_r[0] <= info_nxt;
      for (int s = 1; s < m3i_pkg::DIV_LAT; s++) begin
        info_r[s] <= info_r[s-1];
      end
    end
  end

  // merge lane results and status
  always_comb begin
    if (info_r[m3i_pkg::DIV_LAT-1].sing) begin
      status = m3i_pkg::ST_SINGULAR;
    end else if (info_r[m3i_pkg::DIV_LAT-1].dsat || (|lane_sat)) begin
      status = m3i_pkg::ST_SAT;
    end else begin
      status = m3i_pkg::ST_OK;
    end
    odata = '0;
    for (int k = 0; k < NL; k++) begin
      odata[k*m3i_pkg::EW +: m3i_pkg::EW] =
        info_r[m3i_pkg::DIV_LAT-1].sing ? '0 : lane_val[k];
    end
    odata[NL*m3i_pkg::EW +: m3i_pkg::EW]     = info_r[m3i_pkg::DIV_LAT-1].det;
    odata[(NL+1)*m3i_pkg::EW +: m3i_pkg::ST_W] = status;
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= odata;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");

  a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[321:320] != 2'd3))
    else $error("undefined status code");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[PL-1] && en && info_r[m3i_pkg::DIV_LAT-1].sing) |=>
      (out_tdata_r[287:0] == '0 && out_tdata_r[321:320] == m3i_pkg::ST_SINGULAR))
    else $error("singular result not cleared");

endmodule
`default_nettype wire

FILE: tb/m3i_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module m3i_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  input  wire logic                               in_tready,
  input  wire logic [m3i_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                               out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic [m3i_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [m3i_pkg::THR_W-1:0]          cfg_wdata,
  output int                                      errors,
  output int                                      pending
);

  typedef struct packed {
    logic [m3i_pkg::N_EL-1:0][m3i_pkg::EW-1:0] el;
    logic [m3i_pkg::EW-1:0]                    det;
    logic [m3i_pkg::ST_W-1:0]                  status;
  } inverse_t;

  inverse_t                     inverse_q[$];
  logic [m3i_pkg::THR_W-1:0]    threshold;

  // clamp a magnitude to the Q8.24 range for its sign
  function automatic logic [m3i_pkg::EW-1:0] clamp_q824(input logic neg,
                                                        input logic [127:0] mag,
                                                        inout logic sat);
    logic [127:0] lim;
    logic [127:0] v;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    v = mag;
    if (mag > lim) begin
      v = lim;
      sat = 1'b1;
    end
    return neg ? (-v[m3i_pkg::EW-1:0]) : v[m3i_pkg::EW-1:0];
  endfunction

  function automatic inverse_t invert_matrix(input logic [m3i_pkg::IN_TDATA_W-1:0] mat,
                                             input logic [m3i_pkg::THR_W-1:0] thr);
    inverse_t            res;
    longint              m[9];
    longint              c[9];
    logic signed [127:0] d, a, b;
    logic [127:0]        dm, dr, num, q, r, cm;
    logic                dneg, sat, neg;
    for (int k = 0; k < 9; k++) m[k] = longint'($signed(mat[32*k +: 32]));
    c[0] = m[4] * m[8] - m[7] * m[5];
    c[1] = m[7] * m[2] - m[1] * m[8];
    c[2] = m[1] * m[5] - m[4] * m[2];
    c[3] = m[6] * m[5] - m[3] * m[8];
    c[4] = m[0] * m[8] - m[6] * m[2];
    c[5] = m[3] * m[2] - m[0] * m[5];
    c[6] = m[3] * m[7] - m[6] * m[4];
    c[7] = m[6] * m[1] - m[0] * m[7];
    c[8] = m[0] * m[4] - m[3] * m[1];
    // exact determinant along the first column
    d = '0;
    for (int k = 0; k < 3; k++) begin
      a = m[3*k];
      b = c[k];
      d = d + a * b;
    end
    dneg = d[127];
    dm = dneg ? -d : d;
    sat = 1'b0;
    dr = (dm >> 48) + dm[47];
    res.det = clamp_q824(dneg, dr, sat);
    if (dm == 0 || dm < ({103'd0, thr} << 48)) begin
      res.el = '0;
      res.status = m3i_pkg::ST_SINGULAR;
      return res;
    end
    for (int k = 0; k < 9; k++) begin
      cm = (c[k] < 0) ? -c[k] : c[k];
      cm = cm & 128'hFFFF_FFFF_FFFF_FFFF;
      num = cm << 48;
      q = num / dm;
      r = num % dm;
      if ((r << 1) >= dm) q = q + 1;
      neg = ((c[k] < 0) != dneg) && cm != 0;
      res.el[k] = clamp_q824(neg, q, sat);
    end
    res.status = sat ? m3i_pkg::ST_SAT : m3i_pkg::ST_OK;
    return res;
  endfunction

  // track the register, queue predictions, compare results
  always @(posedge clk) begin
    inverse_t exp_r, got;
    if (!rst_n) begin
      threshold <= m3i_pkg::THR_RESET;
      inverse_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (in_tvalid && in_tready) inverse_q.push_back(invert_matrix(in_tdata, threshold));
      if (out_tvalid && out_tready) begin
        got.el = out_tdata[0 +: 288];
        got.det = out_tdata[288 +: 32];
        got.status = out_tdata[320 +: 2];
        if (inverse_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          exp_r = inverse_q.pop_front();
          if (exp_r != got) begin
            errors <= errors + 1;
            if (errors < 10) begin
              for (int k = 0; k < 9; k++)
                if (exp_r.el[k] != got.el[k])
                  $display("inv_m%0d: expected %h got %h", k, exp_r.el[k], got.el[k]);
              if (exp_r.det != got.det)
                $display("determinant: expected %h got %h", exp_r.det, got.det);
              if (exp_r.status != got.status)
                $display("status: expected %0d got %0d", exp_r.status, got.status);
            end
          end
        end
      end
      pending <= inverse_q.size();
    end
  end
endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int ONE = 1 << 24;

  logic                            clk = 0;
  logic                            rst_n = 0;
  logic                            in_tvalid = 0;
  logic                            in_tready;
  logic [m3i_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 0;
  logic [m3i_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_we = 0;
  logic [m3i_pkg::THR_W-1:0]       cfg_wdata = '0;
  int                              errors, pending;
  int                              sent = 0;
  bit                              quiet = 0;

  always #6 clk = ~clk;

  matrix3_inverse_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  m3i_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  // run limit
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off to back up the pipe
  initial begin
    bit held;
    held = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && sent >= 60) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_elem(input int kind);
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, ONE, 32'h0};
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 2 * ONE) - ONE;
      2: return $urandom_range(0, 512) - 256;
      3: return edges[$urandom_range(0, 5)];
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [m3i_pkg::IN_TDATA_W-1:0] rand_matrix();
    logic [m3i_pkg::IN_TDATA_W-1:0] mat;
    int                             sel, kind;
    sel = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      kind = (sel < 5) ? 1 : (sel == 5) ? 0 : (sel == 6) ? 2 : $urandom_range(0, 4);
      mat[32*k +: 32] = pick_elem(kind);
    end
    // well-conditioned: push the diagonal up
    if (sel < 4)
      for (int k = 0; k < 9; k += 4)
        mat[32*k +: 32] = mat[32*k +: 32] + ($urandom_range(0, 1) ? 3 * ONE : -3 * ONE);
    // rank deficient: third row repeats the first
    if (sel == 9) mat[192 +: 96] = mat[0 +: 96];
    return mat;
  endfunction

  function automatic logic [m3i_pkg::IN_TDATA_W-1:0] diag(input logic [31:0] a,
                                                          input logic [31:0] b,
                                                          input logic [31:0] c);
    logic [m3i_pkg::IN_TDATA_W-1:0] mat;
    mat = '0;
    mat[0 +: 32] = a;
    mat[128 +: 32] = b;
    mat[256 +: 32] = c;
    return mat;
  endfunction

  task automatic send(input logic [m3i_pkg::IN_TDATA_W-1:0] mat);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tdata <= mat;
    in_tvalid <= 1'b1;
    forever begin
      @(negedge clk);
      if (in_tready) break;
    end
    @(posedge clk);
    sent++;
  endtask

  // let the pipe drain, then write the threshold
  task automatic set_threshold(input logic [m3i_pkg::THR_W-1:0] thr);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_wdata <= thr;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [m3i_pkg::THR_W-1:0]      thr_list[4];
    logic [m3i_pkg::IN_TDATA_W-1:0] mat;
    int                             guard;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    thr_list = '{m3i_pkg::THR_RESET, 25'd0, 25'h100_0000, 25'($urandom_range(0, ONE))};

    for (int ph = 0; ph < 4; ph++) begin
      set_threshold(thr_list[ph]);
      // directed corners under each setting
      send(diag(ONE, ONE, ONE));
      send('0);
      send({9{32'h7FFF_FFFF}});
      send({9{32'h8000_0000}});
      send(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send(diag(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
      send(diag(32'd1, 32'd1, 32'd1));
      send(diag(32'd256, ONE, ONE));
      send(diag(32'd168, ONE, ONE));
      send(diag(32'd167, ONE, ONE));
      send(diag(-ONE, 2 * ONE, -(ONE / 2)));
      send(diag(ONE, ONE, 32'h80));
      mat = rand_matrix();
      mat[192 +: 96] = mat[96 +: 96];
      send(mat);
      for (int i = 0; i < 400; i++) begin
        if (ph == 3 && i >= 150) quiet = 1;
        send(rand_matrix());
      end
    end
    in_tvalid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
